### hdl/ddo_pkg.sv
package ddo_pkg;

  localparam int ANGLE_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 30;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_WHEEL_RADIUS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] HEADING_GAIN_RESET      = 16'd9102;
  localparam logic [CFG_DATA_W-1:0] HALF_WHEEL_RADIUS_RESET = 16'd819;

  localparam longint TWO_PI_Q16 = 411775;
  localparam longint PI_Q16     = 205887;
  localparam longint RED_OFFSET = 64'sd2147818400;
  localparam int     RED_TOP    = 13;
  localparam int     RED_IDX_W  = 4;
  localparam int     ROT_IDX_W  = 5;
  localparam logic [63:0] K_Q32 = 64'd2608131496;

  typedef struct packed {
    logic                 load;
    logic                 mul_head;
    logic                 mul_step;
    logic                 head;
    logic                 reduce;
    logic                 fold;
    logic                 rotate;
    logic                 post;
    logic                 mul_x;
    logic                 mul_y;
    logic                 commit;
    logic [RED_IDX_W-1:0] red_idx;
    logic [ROT_IDX_W-1:0] rot_idx;
  } cmd_t;

  function automatic logic [63:0] quarter_pi_q60();
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] a5;
    logic [63:0] a239;
    a5 = '0;
    a239 = '0;
    p = (64'd1 << 60) / 64'd5;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        t = p / 64'(2 * k + 1);
        if (k % 2 == 1) a5 = a5 - t;
        else a5 = a5 + t;
        p = p / 64'd25;
      end
    end
    p = (64'd1 << 60) / 64'd239;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        t = p / 64'(2 * k + 1);
        if (k % 2 == 1) a239 = a239 - t;
        else a239 = a239 + t;
        p = p / 64'd57121;
      end
    end
    return 64'd4 * a5 - a239;
  endfunction

  function automatic logic [63:0] atan_q60(int i);
    logic [63:0] s;
    logic [63:0] t;
    s = '0;
    if (i == 0) begin
      s = quarter_pi_q60();
    end else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 60) begin
          t = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) s = s - t;
          else s = s + t;
        end
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
    if (sh <= 0) return v;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] cordic_atan(int i, int frac);
    return round_shift(atan_q60(i), 60 - frac);
  endfunction

  function automatic logic [63:0] cordic_gain(int frac);
    if (frac <= 32) return round_shift(K_Q32, 32 - frac);
    return K_Q32 << (frac - 32);
  endfunction

endpackage

### hdl/ddo_if.sv
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_angle;
  logic signed [31:0] right_angle;
  modport source(output valid, left_angle, right_angle, input ready);
  modport sink(input valid, left_angle, right_angle, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] heading;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] travel_step;
  logic               saturated;
  modport source(output valid, heading, pos_x, pos_y, travel_step, saturated, input ready);
  modport sink(input valid, heading, pos_x, pos_y, travel_step, saturated, output ready);
endinterface

### hdl/ddo_controller.sv
module ddo_controller #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ddo_pkg::cmd_t cmd
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_MUL_HEAD = 11'b00000000010,
    S_MUL_STEP = 11'b00000000100,
    S_HEAD     = 11'b00000001000,
    S_REDUCE   = 11'b00000010000,
    S_FOLD     = 11'b00000100000,
    S_ROTATE   = 11'b00001000000,
    S_POST     = 11'b00010000000,
    S_MUL_X    = 11'b00100000000,
    S_MUL_Y    = 11'b01000000000,
    S_COMMIT   = 11'b10000000000
  } state_t;

  state_t                          state, state_next;
  logic [ddo_pkg::RED_IDX_W-1:0]   red_cnt;
  logic [IW-1:0]                   rot_cnt;
  logic                            slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_MUL_HEAD;
      S_MUL_HEAD: state_next = S_MUL_STEP;
      S_MUL_STEP: state_next = S_HEAD;
      S_HEAD:     state_next = S_REDUCE;
      S_REDUCE:   if (red_cnt == '0) state_next = S_FOLD;
      S_FOLD:     state_next = S_ROTATE;
      S_ROTATE:   if (rot_cnt == IW'(CORDIC_STEPS - 1)) state_next = S_POST;
      S_POST:     state_next = S_MUL_X;
      S_MUL_X:    state_next = S_MUL_Y;
      S_MUL_Y:    state_next = S_COMMIT;
      S_COMMIT:   if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul_head = (state == S_MUL_HEAD);
    cmd.mul_step = (state == S_MUL_STEP);
    cmd.head     = (state == S_HEAD);
    cmd.reduce   = (state == S_REDUCE);
    cmd.fold     = (state == S_FOLD);
    cmd.rotate   = (state == S_ROTATE);
    cmd.post     = (state == S_POST);
    cmd.mul_x    = (state == S_MUL_X);
    cmd.mul_y    = (state == S_MUL_Y);
    cmd.commit   = (state == S_COMMIT) && slot_free;
    cmd.red_idx  = red_cnt;
    cmd.rot_idx  = ddo_pkg::ROT_IDX_W'(rot_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      red_cnt   <= '0;
      rot_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_HEAD) red_cnt <= ddo_pkg::RED_IDX_W'(ddo_pkg::RED_TOP);
      else if (state == S_REDUCE) red_cnt <= red_cnt - 1'b1;
      if (state == S_FOLD) rot_cnt <= '0;
      else if (state == S_ROTATE) rot_cnt <= rot_cnt + 1'b1;
    end
  end

endmodule

### hdl/ddo_datapath.sv
module ddo_datapath #(
  parameter int ANGLE_WIDTH  = ddo_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ddo_pkg::cmd_t                      cmd,
  input  logic signed [31:0]                 left_angle,
  input  logic signed [31:0]                 right_angle,
  output logic signed [31:0]                 heading,
  output logic signed [31:0]                 pos_x,
  output logic signed [31:0]                 pos_y,
  output logic signed [31:0]                 travel_step,
  output logic                               saturated
);

  localparam int AW   = ANGLE_WIDTH;
  localparam int FRAC = AW - 2;
  localparam int SH_Z = 60 - FRAC;
  localparam int IW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SH_Q = (FRAC >= 30) ? FRAC - 30 : 0;
  localparam int SL_Q = (FRAC >= 30) ? 0 : 30 - FRAC;
  localparam logic signed [63:0] RND_Q  = (SH_Q > 0) ? (64'sd1 <<< ((SH_Q > 0) ? SH_Q - 1 : 0))
                                                     : 64'sd0;
  localparam logic signed [63:0] RND_Z  = 64'sd1 <<< (SH_Z - 1);
  localparam logic signed [63:0] QPI    = $signed(ddo_pkg::quarter_pi_q60());
  localparam logic signed [63:0] HALF_PI = QPI <<< 1;
  localparam logic signed [63:0] PI_Q60  = QPI <<< 2;
  localparam logic signed [AW-1:0] X_INIT = AW'(ddo_pkg::cordic_gain(FRAC));

  function automatic logic [32:0] sat32(logic signed [67:0] v);
    if (v > 68'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -68'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  logic [15:0]             gain, hwr;
  logic signed [31:0]      l_lat, r_lat, prev_l, prev_r;
  logic signed [31:0]      head_w, step_w, nx_w;
  logic                    sat_w, flip;
  logic signed [33:0]      ma, mb, wheel_sum;
  logic signed [67:0]      prod, r16, r30, pos_sum;
  logic [32:0]             s16, sp;
  logic signed [32:0]      hsum;
  logic signed [31:0]      mean;
  logic [32:0]             u, cand;
  logic [18:0]             rr;
  logic signed [19:0]      rs;
  logic signed [63:0]      z60, zf, zr;
  logic signed [AW-1:0]    x, y, z, xs, ys, xo, yo;
  logic signed [63:0]      qx, qy;
  logic signed [32:0]      cos_v, sin_v;
  logic signed [AW-1:0]    atan_tab [CORDIC_STEPS];
  logic [IW-1:0]           ri;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    assign atan_tab[g] = AW'(ddo_pkg::cordic_atan(g, FRAC));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= ddo_pkg::HEADING_GAIN_RESET;
      hwr  <= ddo_pkg::HALF_WHEEL_RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ddo_pkg::REG_HEADING_GAIN:      gain <= cfg_data;
        ddo_pkg::REG_HALF_WHEEL_RADIUS: hwr  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wheel_sum = (34'(r_lat) - 34'(prev_r)) + (34'(l_lat) - 34'(prev_l));

  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.mul_head) begin
      ma = 34'(r_lat) - 34'(l_lat);
      mb = $signed({18'b0, gain});
    end else if (cmd.mul_step) begin
      ma = wheel_sum;
      mb = $signed({18'b0, hwr});
    end else if (cmd.mul_x) begin
      ma = 34'(step_w);
      mb = 34'(cos_v);
    end else if (cmd.mul_y) begin
      ma = 34'(step_w);
      mb = 34'(sin_v);
    end
  end

  assign r16     = (prod + 68'sd32768) >>> 16;
  assign s16     = sat32(r16);
  assign r30     = (prod + (68'sd1 <<< 29)) >>> 30;
  assign hsum    = 33'(heading) + 33'(head_w);
  assign mean    = hsum[32:1];
  assign cand    = 33'(ddo_pkg::TWO_PI_Q16) << cmd.red_idx;
  assign rr      = u[18:0];
  assign rs      = (20'(rr) > 20'(ddo_pkg::PI_Q16)) ? $signed({1'b0, rr}) - 20'sd411775
                                                    : $signed({1'b0, rr});
  assign z60     = 64'(rs) <<< 44;
  assign ri      = cmd.rot_idx[IW-1:0];
  assign xs      = x >>> ri;
  assign ys      = y >>> ri;
  assign xo      = flip ? -x : x;
  assign yo      = flip ? -y : y;
  assign qx      = ((64'(xo) + RND_Q) >>> SH_Q) <<< SL_Q;
  assign qy      = ((64'(yo) + RND_Q) >>> SH_Q) <<< SL_Q;

  always_comb begin
    zf = z60;
    if (z60 > HALF_PI) zf = z60 - PI_Q60;
    else if (z60 < -HALF_PI) zf = z60 + PI_Q60;
  end
  assign zr = (zf + RND_Z) >>> SH_Z;

  always_comb begin
    if (cmd.mul_y) pos_sum = 68'(pos_x) + r30;
    else pos_sum = 68'(pos_y) + r30;
  end
  assign sp = sat32(pos_sum);

  always_ff @(posedge clk) begin
    if (cmd.mul_head || cmd.mul_step || cmd.mul_x || cmd.mul_y) prod <= ma * mb;
    if (cmd.load) begin
      l_lat <= left_angle;
      r_lat <= right_angle;
    end
    if (cmd.mul_step) begin
      head_w <= $signed(s16[31:0]);
      sat_w  <= s16[32];
    end
    if (cmd.head) begin
      step_w <= $signed(s16[31:0]);
      u      <= 33'(mean) + 33'(ddo_pkg::RED_OFFSET);
    end
    if (cmd.reduce && u >= cand) u <= u - cand;
    if (cmd.fold) begin
      flip <= (z60 > HALF_PI) || (z60 < -HALF_PI);
      z    <= zr[AW-1:0];
      x    <= X_INIT;
      y    <= '0;
    end
    if (cmd.rotate) begin
      if (!z[AW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_tab[ri];
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_tab[ri];
      end
    end
    if (cmd.post) begin
      cos_v <= qx[32:0];
      sin_v <= qy[32:0];
    end
    if (cmd.mul_y) begin
      nx_w  <= $signed(sp[31:0]);
      sat_w <= sat_w | sp[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_l      <= '0;
      prev_r      <= '0;
      heading     <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      travel_step <= '0;
      saturated   <= 1'b0;
    end else if (cmd.commit) begin
      prev_l      <= l_lat;
      prev_r      <= r_lat;
      heading     <= head_w;
      pos_x       <= nx_w;
      pos_y       <= $signed(sp[31:0]);
      travel_step <= step_w;
      saturated   <= sat_w | sp[32];
    end
  end

endmodule

### hdl/diff_drive_odometry.sv
// Differential-drive odometry, one pose update per accepted item.
// Each accepted item runs through the heading and step multiplies, the angle reduction
// loop, the CORDIC loop and the x and y multiplies; an unread result holds the commit.
// A new item is accepted only in idle, after the previous result has been committed.
// Reset: synchronous, active high; clears pose, history and restores register defaults.
module diff_drive_odometry #(
  parameter int ANGLE_WIDTH  = ddo_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ddo_in_if.sink                          wheels,
  ddo_out_if.source                       pose,
  input  logic                            cfg_we,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ddo_pkg::cmd_t cmd;

  ddo_controller #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (wheels.valid),
    .in_ready (wheels.ready),
    .out_valid(pose.valid),
    .out_ready(pose.ready),
    .cmd      (cmd)
  );

  ddo_datapath #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .left_angle (wheels.left_angle),
    .right_angle(wheels.right_angle),
    .heading    (pose.heading),
    .pos_x      (pose.pos_x),
    .pos_y      (pose.pos_y),
    .travel_step(pose.travel_step),
    .saturated  (pose.saturated)
  );

endmodule

### hdl/ddo_checker.sv
module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] heading,
  input logic [31:0] pos_x
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("new item taken while one is at work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(pos_x))
    else $error("stalled result changed");

  a_result_needs_item: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_ready |=> !out_valid)
    else $error("result without an item");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (wheels.valid),
  .in_ready (wheels.ready),
  .out_valid(pose.valid),
  .out_ready(pose.ready),
  .heading  (pose.heading),
  .pos_x    (pose.pos_x)
);

### tb/sv/tb_diff_drive_odometry.sv
module tb_diff_drive_odometry;
  import ddo_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int  DRAIN_CYCLES = 10 + CORDIC_STEPS_DEF + RED_TOP + 20;
  localparam longint K_GAIN = 64'sd2608131496;

  typedef struct packed {
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
  } wheels_t;

  typedef struct packed {
    logic signed [31:0] heading;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] travel_step;
    logic               saturated;
  } pose_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ddo_in_if  wheels();
  ddo_out_if pose();

  diff_drive_odometry i_dut (
    .clk(clk), .rst(rst), .wheels(wheels), .pose(pose),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wheels_t pending_ticks[$];
  pose_t   expected_poses[$];
  int      errors;
  int      n_items;
  int      n_poses;
  int      n_clipped;
  bit      hold_sender;
  bit      calm;
  int      send_gap;
  int      stall_left;

  // odometry state mirror
  longint gain_q16;
  longint hwr_q16;
  longint last_left, last_right, last_heading, x_acc, y_acc;
  longint atan_q30[CORDIC_STEPS_DEF];
  longint pi_q60;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint arctan_inv(longint n);
    longint p, s, k;
    p = (longint'(1) << 60) / n;
    s = 0;
    k = 0;
    while (p != 0) begin
      if (k % 2 == 1) s -= p / (2 * k + 1);
      else s += p / (2 * k + 1);
      p = p / (n * n);
      k++;
    end
    return s;
  endfunction

  function automatic longint arctan_pow2(int i);
    longint s;
    s = 0;
    for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
      if (k % 2 == 1) s -= (longint'(1) << (60 - i * (2 * k + 1))) / (2 * k + 1);
      else s += (longint'(1) << (60 - i * (2 * k + 1))) / (2 * k + 1);
    end
    return s;
  endfunction

  task automatic build_atan_table();
    longint qpi;
    qpi = 4 * arctan_inv(5) - arctan_inv(239);
    pi_q60 = 4 * qpi;
    atan_q30[0] = rnd_shift(qpi, 30);
    for (int i = 1; i < CORDIC_STEPS_DEF; i++) atan_q30[i] = rnd_shift(arctan_pow2(i), 30);
  endtask

  task automatic rotate_heading(longint ang, output longint c, output longint s);
    longint r, z, x, y, xs, ys;
    bit flip;
    flip = 0;
    r = ang % TWO_PI_Q16;
    if (r < 0) r += TWO_PI_Q16;
    if (r > PI_Q16) r -= TWO_PI_Q16;
    z = r <<< 44;
    if (z > pi_q60 / 2) begin
      z -= pi_q60;
      flip = 1;
    end else if (z < -(pi_q60 / 2)) begin
      z += pi_q60;
      flip = 1;
    end
    z = rnd_shift(z, 30);
    x = rnd_shift(K_GAIN, 2);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q30[i];
      end else begin
        x += ys; y -= xs; z += atan_q30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(wheels_t w);
    longint l, r, head, step, mean, c, s, nx, ny;
    bit hit, spare;
    pose_t p;
    hit = 0;
    spare = 0;
    l = w.left_angle;
    r = w.right_angle;
    head = clip32(rnd_shift(gain_q16 * (r - l), 16), hit);
    step = clip32(rnd_shift(hwr_q16 * ((r - last_right) + (l - last_left)), 16), spare);
    mean = (last_heading + head) >>> 1;
    rotate_heading(mean, c, s);
    nx = clip32(x_acc + rnd_shift(step * c, 30), hit);
    ny = clip32(y_acc + rnd_shift(step * s, 30), hit);
    last_left = l;
    last_right = r;
    last_heading = head;
    x_acc = nx;
    y_acc = ny;
    p.heading = head[31:0];
    p.pos_x = nx[31:0];
    p.pos_y = ny[31:0];
    p.travel_step = step[31:0];
    p.saturated = hit;
    expected_poses.push_back(p);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 70);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // wheel tick driver
  always @(posedge clk) begin
    if (rst) begin
      wheels.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (wheels.valid && wheels.ready) begin
        predict_pose({wheels.left_angle, wheels.right_angle});
        n_items++;
      end
      if (!wheels.valid || wheels.ready) begin
        if (send_gap > 0 || hold_sender || pending_ticks.size() == 0) begin
          wheels.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          wheels_t t;
          t = pending_ticks.pop_front();
          wheels.valid <= 1'b1;
          wheels.left_angle <= t.left_angle;
          wheels.right_angle <= t.right_angle;
          send_gap <= pick_gap();
        end
      end
    end
  end

  // pose monitor
  always @(posedge clk) begin
    if (rst) begin
      pose.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pose.valid && pose.ready) begin
        n_poses++;
        if (expected_poses.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (e.saturated) n_clipped++;
          if (pose.heading !== e.heading) report("heading", pose.heading, e.heading);
          if (pose.pos_x !== e.pos_x) report("pos_x", pose.pos_x, e.pos_x);
          if (pose.pos_y !== e.pos_y) report("pos_y", pose.pos_y, e.pos_y);
          if (pose.travel_step !== e.travel_step)
            report("travel_step", pose.travel_step, e.travel_step);
          if (pose.saturated !== e.saturated) report("saturated", pose.saturated, e.saturated);
        end
      end
      if (stall_left > 0) begin
        pose.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pose.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        pose.ready <= 1'b1;
      end
    end
  end

  task automatic add_tick(longint l, longint r);
    wheels_t t;
    t.left_angle = l[31:0];
    t.right_angle = r[31:0];
    pending_ticks.push_back(t);
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || expected_poses.size() != 0 || wheels.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEADING_GAIN) gain_q16 = val;
    else if (idx == REG_HALF_WHEEL_RADIUS) hwr_q16 = val;
  endtask

  task automatic add_drive(int count);
    logic signed [31:0] gl, gr;
    int m, k;
    gl = 0;
    gr = 0;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: m = 64;
        1: m = 4096;
        2: m = 262144;
        default: m = 8388608;
      endcase
      if (k < 7) begin
        gl = gl + ($signed($urandom_range(0, 2 * m)) - m);
        gr = gr + ($signed($urandom_range(0, 2 * m)) - m);
      end else if (k < 9) begin
        gl = $urandom;
        gr = $urandom;
      end
      add_tick(gl, gr);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wheels.valid = 1'b0;
    wheels.left_angle = '0;
    wheels.right_angle = '0;
    pose.ready = 1'b0;
    errors = 0;
    n_items = 0;
    n_poses = 0;
    n_clipped = 0;
    hold_sender = 0;
    calm = 0;
    gain_q16 = HEADING_GAIN_RESET;
    hwr_q16 = HALF_WHEEL_RADIUS_RESET;
    last_left = 0;
    last_right = 0;
    last_heading = 0;
    x_acc = 0;
    y_acc = 0;
    build_atan_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_tick(0, 0);
    add_tick(65536, 0);
    add_tick(0, 65536);
    add_tick(-1, 1);
    add_tick(1, -1);
    add_tick(-2147483648, 2147483647);
    add_tick(2147483647, -2147483648);
    add_tick(2147483647, 2147483647);
    add_tick(-2147483648, -2147483648);
    add_tick(0, 1500000);
    add_tick(0, 3000000);
    add_tick(0, -3000000);
    add_drive(230);
    wait_idle();

    write_reg(REG_HEADING_GAIN, 16'hFFFF);
    write_reg(REG_HALF_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'h0000);
    write_reg(REG_SPARE_3, 16'h1234);
    // drive the pose into the clip limits
    for (int i = 0; i < 6; i++) begin
      add_tick(2147483647, -2147483648);
      add_tick(-2147483648, 2147483647);
    end
    calm = 1;
    add_drive(230);
    wait_idle();
    calm = 0;

    write_reg(REG_HEADING_GAIN, 16'h0000);
    write_reg(REG_HALF_WHEEL_RADIUS, 16'h0000);
    add_drive(230);
    wait_idle();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(REG_HEADING_GAIN, 16'($urandom));
      write_reg(REG_HALF_WHEEL_RADIUS, 16'($urandom));
      add_drive(115);
      hold_sender = 1;
      while (expected_poses.size() != 0 || wheels.valid) @(posedge clk);
      hold_sender = 0;
      add_drive(115);
      wait_idle();
    end

    if (expected_poses.size() != 0) report("items left over", expected_poses.size(), 0);
    $display("covered %0d wheel ticks, %0d poses checked, %0d with clipping",
             n_items, n_poses, n_clipped);
    $display("register settings: reset, both max, both zero, two random");
    if (errors == 0) begin
      $display("tb_diff_drive_odometry OK");
    end else begin
      $display("tb_diff_drive_odometry NOT OK");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb_diff_drive_odometry NOT OK");
    $finish;
  end

endmodule
